// ----- hdl/assert_macros.svh -----
// -----------------------------------------------------------------------------
// assert_macros
// assertion macros included by the top-level rtl file
// -----------------------------------------------------------------------------
// each check is clocked on the rising edge and held off while reset is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define SMU_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("smu assertion failed");

// expression must never be true outside reset
`define SMU_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("smu forbidden condition seen");

`else

`define SMU_ASSERT(label, clk, rst, prop)
`define SMU_ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

// ----- hdl/smu_pkg.sv -----
// -----------------------------------------------------------------------------
// smu_pkg
// shared constants and command/status types of the lifo stack machine
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package smu_pkg;

   localparam int DEFAULT_DEPTH = 64;

   localparam int OP_W     = 3;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 7;

   // operation codes
   localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
   localparam logic [OP_W-1:0] OP_POP  = 3'd1;
   localparam logic [OP_W-1:0] OP_SWAP = 3'd2;
   localparam logic [OP_W-1:0] OP_ADD  = 3'd3;
   localparam logic [OP_W-1:0] OP_NOP  = 3'd4;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] ST_POP_EMPTY  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_SWAP_SHORT = 3'd2;
   localparam logic [STATUS_W-1:0] ST_ADD_SHORT  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW   = 3'd4;
   localparam logic [STATUS_W-1:0] ST_HALTED     = 3'd5;

   // controller to datapath
   typedef struct packed {
      logic accept;   // latch the item, launch the read below top
      logic exec;     // carry out the operation
      logic swap2;    // second write of a swap
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic swap_more;   // swap in progress needs its second write
   } sts_type;

endpackage

`default_nettype wire

// ----- hdl/smu_dpath.sv -----
// -----------------------------------------------------------------------------
// smu_dpath
// stack store, cached top entry, entry count, halt flag and result registers
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smu_dpath #(
   parameter int Depth = smu_pkg::DEFAULT_DEPTH
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire smu_pkg::cmd_type                  cmd,
   output smu_pkg::sts_type                       sts,
   input  wire logic [smu_pkg::OP_W-1:0]          req_type,
   input  wire logic signed [smu_pkg::DATA_W-1:0] req_push_value,
   output logic [smu_pkg::STATUS_W-1:0]           rsp_status,
   output logic signed [smu_pkg::DATA_W-1:0]      rsp_top_value,
   output logic                                   rsp_top_valid,
   output logic [smu_pkg::COUNT_W-1:0]            rsp_entry_count
);

   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CW = $clog2(Depth + 1);

   logic [smu_pkg::DATA_W-1:0]   stack_mem [Depth];

   logic [smu_pkg::OP_W-1:0]     op_ff, op_in;
   logic [smu_pkg::DATA_W-1:0]   val_ff, val_in;
   logic [smu_pkg::DATA_W-1:0]   top_ff, top_in;
   logic [smu_pkg::DATA_W-1:0]   rd_data_ff;
   logic [CW-1:0]                cnt_ff, cnt_in;
   logic                         halted_ff, halted_in;
   logic [smu_pkg::STATUS_W-1:0] status_ff, status_in;

   logic [smu_pkg::STATUS_W-1:0] exec_status;
   logic [CW-1:0]                cnt_m1, cnt_m2;
   logic                         rd_en;
   logic                         wr_en;
   logic [AW-1:0]                wr_addr;
   logic [smu_pkg::DATA_W-1:0]   wr_data;

   assign cnt_m1 = cnt_ff - CW'(1);
   assign cnt_m2 = cnt_ff - CW'(2);
   // entry below the top lives at count-2; only read when it exists
   assign rd_en  = cmd.accept && (cnt_ff >= CW'(2));

   always_comb begin
      if (halted_ff) begin
         exec_status = smu_pkg::ST_HALTED;
      end else begin
         case (op_ff)
            smu_pkg::OP_PUSH:
               exec_status = (cnt_ff == CW'(Depth)) ? smu_pkg::ST_OVERFLOW : smu_pkg::ST_OK;
            smu_pkg::OP_POP:
               exec_status = (cnt_ff == '0) ? smu_pkg::ST_POP_EMPTY : smu_pkg::ST_OK;
            smu_pkg::OP_SWAP:
               exec_status = (cnt_ff < CW'(2)) ? smu_pkg::ST_SWAP_SHORT : smu_pkg::ST_OK;
            smu_pkg::OP_ADD:
               exec_status = (cnt_ff < CW'(2)) ? smu_pkg::ST_ADD_SHORT : smu_pkg::ST_OK;
            default:
               exec_status = smu_pkg::ST_OK;
         endcase
      end
   end

   assign sts.swap_more = (op_ff == smu_pkg::OP_SWAP) && (exec_status == smu_pkg::ST_OK);

   always_comb begin
      op_in     = op_ff;
      val_in    = val_ff;
      top_in    = top_ff;
      cnt_in    = cnt_ff;
      halted_in = halted_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      wr_addr   = cnt_m2[AW-1:0];
      wr_data   = top_ff;

      if (cmd.accept) begin
         op_in  = req_type;
         val_in = req_push_value;
      end

      if (cmd.exec) begin
         status_in = exec_status;
         if (exec_status != smu_pkg::ST_OK) begin
            halted_in = 1'b1;
         end else begin
            case (op_ff)
               smu_pkg::OP_PUSH: begin
                  wr_en   = 1'b1;
                  wr_addr = cnt_ff[AW-1:0];
                  wr_data = val_ff;
                  top_in  = val_ff;
                  cnt_in  = cnt_ff + CW'(1);
               end
               smu_pkg::OP_POP: begin
                  top_in = rd_data_ff;
                  cnt_in = cnt_m1;
               end
               smu_pkg::OP_SWAP: begin
                  // old top goes down, second entry comes up
                  wr_en   = 1'b1;
                  wr_data = top_ff;
                  top_in  = rd_data_ff;
               end
               smu_pkg::OP_ADD: begin
                  wr_en   = 1'b1;
                  wr_data = rd_data_ff + top_ff;
                  top_in  = rd_data_ff + top_ff;
                  cnt_in  = cnt_m1;
               end
               default: begin
               end
            endcase
         end
      end

      if (cmd.swap2) begin
         wr_en   = 1'b1;
         wr_addr = cnt_m1[AW-1:0];
         wr_data = top_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= stack_mem[cnt_m2[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         halted_ff <= 1'b0;
      end else begin
         cnt_ff    <= cnt_in;
         halted_ff <= halted_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      val_ff    <= val_in;
      top_ff    <= top_in;
      status_ff <= status_in;
   end

   assign rsp_status      = status_ff;
   assign rsp_top_valid   = (cnt_ff != '0);
   assign rsp_top_value   = (cnt_ff != '0) ? top_ff : '0;
   assign rsp_entry_count = smu_pkg::COUNT_W'(cnt_ff);

endmodule

`default_nettype wire

// ----- hdl/smu_ctrl.sv -----
// -----------------------------------------------------------------------------
// smu_ctrl
// sequencer: accept, execute, optional second swap write, hold result
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smu_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output smu_pkg::cmd_type      cmd,
   input  wire smu_pkg::sts_type sts
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_EXEC  = 2'd1;
   localparam logic [1:0] S_SWAP2 = 2'd2;
   localparam logic [1:0] S_RESP  = 2'd3;

   logic [1:0] state_ff, state_in;

   assign req_stall  = (state_ff != S_IDLE);
   assign rsp_valid  = (state_ff == S_RESP);
   assign cmd.accept = req_valid && (state_ff == S_IDLE);
   assign cmd.exec   = (state_ff == S_EXEC);
   assign cmd.swap2  = (state_ff == S_SWAP2);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = sts.swap_more ? S_SWAP2 : S_RESP;
         end
         S_SWAP2: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/stack_machine_push_pop_swap_add_unit.sv -----
// -----------------------------------------------------------------------------
// stack_machine_push_pop_swap_add_unit
// bounded lifo stack of signed 32-bit values: push, pop, swap, add, nop
// -----------------------------------------------------------------------------
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    req_type, req_push_value
//   rsp      out        rsp_valid/stall    rsp_status, rsp_top_value,
//                                          rsp_top_valid, rsp_entry_count
//
// an item passes through accept, execute and result, and waits in result while rsp_stall
// is high; swap adds a second write step, since the store has a single write port and swap writes twice.
// the entry below the top comes from a registered memory read launched at accept.
// reset clears the entry count and the halt flag; the store itself is not cleared.
// req_stall is high from accept until the result item has been taken.
// after an error every item returns the halted status and leaves the stack alone.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module stack_machine_push_pop_swap_add_unit #(
   parameter int STACK_DEPTH = smu_pkg::DEFAULT_DEPTH
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [smu_pkg::OP_W-1:0]          req_type,
   input  wire logic signed [smu_pkg::DATA_W-1:0] req_push_value,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [smu_pkg::STATUS_W-1:0]           rsp_status,
   output logic signed [smu_pkg::DATA_W-1:0]      rsp_top_value,
   output logic                                   rsp_top_valid,
   output logic [smu_pkg::COUNT_W-1:0]            rsp_entry_count
);

   smu_pkg::cmd_type cmd;
   smu_pkg::sts_type sts;

   smu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   smu_dpath #(
      .Depth (STACK_DEPTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_type        (req_type),
      .req_push_value  (req_push_value),
      .rsp_status      (rsp_status),
      .rsp_top_value   (rsp_top_value),
      .rsp_top_valid   (rsp_top_valid),
      .rsp_entry_count (rsp_entry_count)
   );

   // an accepted item always passes through execute before its result shows
   `SMU_ASSERT(a_accept_no_rsp, clock, reset, (req_valid && !req_stall) |=> !rsp_valid)
   // once a result is taken the block is ready for the next item
   `SMU_ASSERT(a_rsp_then_ready, clock, reset, (rsp_valid && !rsp_stall) |=> !req_stall)
   // input and result sides are never open in the same cycle
   `SMU_ASSERT_NEVER(a_one_side_open, clock, reset, rsp_valid && !req_stall)
   // an empty stack reports a zero top value
   `SMU_ASSERT(a_empty_top_zero, clock, reset, (rsp_valid && !rsp_top_valid) |-> (rsp_top_value == '0))

endmodule

`default_nettype wire
